/* src/swr_pkg.sv */
// Shared types, codes and the backoff wait table for the stop-and-wait receiver.
// No dependencies.
package swr_pkg;

	localparam logic [9:0] MAX_PACKET_BYTES = 10'd548;
	localparam logic [9:0] HEADER_BYTES     = 10'd12;
	localparam logic [5:0] LAST_LEVEL       = 6'd39;
	localparam logic [5:0] TOP_LEVEL        = 6'd63;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_RECV = 2'd1,
		PH_STOP = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		CFG_START_LEVEL = 2'd0,
		CFG_RECV_GIVE_UP = 2'd1,
		CFG_STOP_GIVE_UP = 2'd2
	} cfg_reg_t;

	localparam logic [7:0] PKT_SEND        = 8'd0;
	localparam logic [7:0] PKT_INIT        = 8'd2;
	localparam logic [7:0] PKT_STOP        = 8'd4;
	localparam logic [7:0] PKT_STOP_REALLY = 8'd6;

	localparam logic [7:0] RPL_NONE     = 8'd0;
	localparam logic [7:0] RPL_ACK      = 8'd1;
	localparam logic [7:0] RPL_INIT_ACK = 8'd3;
	localparam logic [7:0] RPL_STOP_ACK = 8'd5;

	localparam logic [2:0] ST_IGNORED   = 3'd0;
	localparam logic [2:0] ST_OPENED    = 3'd1;
	localparam logic [2:0] ST_DATA      = 3'd2;
	localparam logic [2:0] ST_STOP_SEEN = 3'd3;
	localparam logic [2:0] ST_COMPLETE  = 3'd4;
	localparam logic [2:0] ST_TIMEOUT   = 3'd5;
	localparam logic [2:0] ST_ABANDONED = 3'd6;

	function automatic logic [18:0] level_wait(input logic [5:0] lvl);
		logic [5:0]  idx;
		logic [18:0] us;
		idx = (lvl > LAST_LEVEL) ? LAST_LEVEL : lvl;
		case (idx[5:2])
			4'd0: us = 19'd1000;
			4'd1: us = 19'd2000;
			4'd2: us = 19'd4000;
			4'd3: us = 19'd8000;
			4'd4: us = 19'd16000;
			4'd5: us = 19'd31000;
			4'd6: us = 19'd63000;
			4'd7: us = 19'd125000;
			4'd8: us = 19'd250000;
			default: us = 19'd500000;
		endcase
		return us;
	endfunction

endpackage

/* src/stop_and_wait_receiver.sv */
// Stop-and-wait receiver: session phase, expected sequence and backoff level.
// Depends on swr_pkg.
//
//  channel  handshake            payload
//  in       in_valid / in_stall  command, pkt_type, pkt_seq, pkt_length
//  out      out_valid / out_stall send_reply, reply_type, reply_seq,
//                                payload_bytes, status, phase_now, wait_us
//  cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled; each item passes
// through the input register, then the result register, which drives the outputs.
// Reset returns the phase to idle, clears sequence and level, loads register defaults.
// A stall on the output while the result register is full holds both registers
// and raises in_stall once the input register is full. cfg_ready is always high.
module stop_and_wait_receiver
	import swr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [7:0]  pkt_type,
	input  logic [31:0] pkt_seq,
	input  logic [9:0]  pkt_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        send_reply,
	output logic [7:0]  reply_type,
	output logic [31:0] reply_seq,
	output logic [9:0]  payload_bytes,
	output logic [2:0]  status,
	output logic [1:0]  phase_now,
	output logic [18:0] wait_us,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [5:0]  cfg_data
);

	logic        valid_s1;
	logic        command_s1;
	logic [7:0]  type_s1;
	logic [31:0] seq_s1;
	logic [9:0]  len_s1;

	logic        valid_s2;
	logic        send_s2;
	logic [7:0]  rtype_s2;
	logic [31:0] rseq_s2;
	logic [9:0]  payload_s2;
	logic [2:0]  status_s2;
	logic [1:0]  phase_s2;
	logic [18:0] wait_s2;

	phase_t      phase_q, phase_n;
	logic [31:0] exp_seq_q, exp_seq_n;
	logic [5:0]  level_q, level_n;
	logic [5:0]  start_level_q, recv_give_up_q, stop_give_up_q;

	logic        advance, load_s1, step;
	logic [9:0]  len_c, body_c;
	logic        pkt_ok, seq_match;
	logic [31:0] seq_sum;
	logic [5:0]  level_inc;

	logic        send_c;
	logic [7:0]  rtype_c;
	logic [31:0] rseq_c;
	logic [9:0]  payload_c;
	logic [2:0]  status_c;

	assign advance  = !valid_s2 || !out_stall;
	assign load_s1  = !valid_s1 || advance;
	assign step     = valid_s1 && advance;
	assign in_stall = !load_s1;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_level_q  <= 6'd10;
			recv_give_up_q <= 6'd40;
			stop_give_up_q <= 6'd32;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_START_LEVEL:  start_level_q  <= cfg_data;
				CFG_RECV_GIVE_UP: recv_give_up_q <= cfg_data;
				CFG_STOP_GIVE_UP: stop_give_up_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			command_s1 <= command;
			type_s1    <= pkt_type;
			seq_s1     <= pkt_seq;
			len_s1     <= pkt_length;
		end
	end

	always_comb begin
		len_c     = (len_s1 > MAX_PACKET_BYTES) ? MAX_PACKET_BYTES : len_s1;
		pkt_ok    = !command_s1 && (len_c >= HEADER_BYTES);
		body_c    = len_c - HEADER_BYTES;
		seq_match = (seq_s1 == exp_seq_q);
		seq_sum   = exp_seq_q + {22'd0, body_c};
		level_inc = (level_q < TOP_LEVEL) ? level_q + 6'd1 : level_q;
	end

	always_comb begin
		phase_n   = phase_q;
		exp_seq_n = exp_seq_q;
		level_n   = level_q;
		case (phase_q)
			PH_RECV: begin
				if (command_s1) begin
					level_n = level_inc;
					if (level_inc >= recv_give_up_q) phase_n = PH_IDLE;
				end else if (pkt_ok && (type_s1 == PKT_SEND || type_s1 == PKT_STOP)
						&& seq_match) begin
					exp_seq_n = seq_sum;
					level_n   = start_level_q;
					if (type_s1 == PKT_STOP) phase_n = PH_STOP;
				end
			end
			PH_STOP: begin
				if (command_s1) begin
					level_n = level_inc;
					if (level_inc >= stop_give_up_q) phase_n = PH_IDLE;
				end else if (pkt_ok && type_s1 == PKT_STOP_REALLY && seq_match) begin
					phase_n = PH_IDLE;
				end
			end
			default: begin
				phase_n = PH_IDLE;
				if (pkt_ok && type_s1 == PKT_INIT) begin
					exp_seq_n = seq_s1;
					level_n   = start_level_q;
					phase_n   = PH_RECV;
				end
			end
		endcase
	end

	always_comb begin
		send_c    = 1'b0;
		rtype_c   = RPL_NONE;
		rseq_c    = 32'd0;
		payload_c = 10'd0;
		status_c  = ST_IGNORED;
		case (phase_q)
			PH_RECV: begin
				if (command_s1) begin
					send_c  = 1'b1;
					rtype_c = RPL_ACK;
					rseq_c  = exp_seq_q;
					if (level_inc >= recv_give_up_q) status_c = ST_TIMEOUT;
				end else if (pkt_ok && (type_s1 == PKT_SEND || type_s1 == PKT_STOP)
						&& seq_match) begin
					send_c = 1'b1;
					rseq_c = seq_sum;
					if (type_s1 == PKT_STOP) begin
						rtype_c  = RPL_STOP_ACK;
						status_c = ST_STOP_SEEN;
					end else begin
						rtype_c   = RPL_ACK;
						payload_c = body_c;
						status_c  = ST_DATA;
					end
				end
			end
			PH_STOP: begin
				if (command_s1) begin
					if (level_inc >= stop_give_up_q) begin
						status_c = ST_ABANDONED;
					end else begin
						send_c  = 1'b1;
						rtype_c = RPL_STOP_ACK;
						rseq_c  = exp_seq_q;
					end
				end else if (pkt_ok && type_s1 == PKT_STOP_REALLY && seq_match) begin
					status_c = ST_COMPLETE;
				end
			end
			default: begin
				if (pkt_ok && type_s1 == PKT_INIT) begin
					send_c   = 1'b1;
					rtype_c  = RPL_INIT_ACK;
					rseq_c   = seq_s1;
					status_c = ST_OPENED;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			exp_seq_q <= 32'd0;
			level_q   <= 6'd0;
			valid_s2  <= 1'b0;
		end else begin
			if (advance) valid_s2 <= valid_s1;
			if (step) begin
				phase_q   <= phase_n;
				exp_seq_q <= exp_seq_n;
				level_q   <= level_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			send_s2    <= send_c;
			rtype_s2   <= rtype_c;
			rseq_s2    <= rseq_c;
			payload_s2 <= payload_c;
			status_s2  <= status_c;
			phase_s2   <= phase_n;
			wait_s2    <= (phase_n == PH_IDLE) ? 19'd0 : level_wait(level_n);
		end
	end

	assign out_valid     = valid_s2;
	assign send_reply    = send_s2;
	assign reply_type    = rtype_s2;
	assign reply_seq     = rseq_s2;
	assign payload_bytes = payload_s2;
	assign status        = status_s2;
	assign phase_now     = phase_s2;
	assign wait_us       = wait_s2;

endmodule

/* src/swr_checker.sv */
// Port-level checks for the stop-and-wait receiver, bound to its top level.
// Depends on swr_pkg and stop_and_wait_receiver.
module swr_checker
	import swr_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        send_reply,
	input logic [7:0]  reply_type,
	input logic [31:0] reply_seq,
	input logic [9:0]  payload_bytes,
	input logic [2:0]  status,
	input logic [1:0]  phase_now,
	input logic [18:0] wait_us
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(reply_seq) && $stable(status)
			&& $stable(wait_us) && $stable(payload_bytes))
		else $error("stalled output transaction changed");

	a_idle_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && phase_now == PH_IDLE |-> wait_us == 19'd0)
		else $error("wait armed while idle");

	a_no_reply: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !send_reply |-> reply_type == RPL_NONE && reply_seq == 32'd0)
		else $error("reply fields set without a reply");

	a_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_DATA |-> send_reply && reply_type == RPL_ACK
			&& phase_now == PH_RECV)
		else $error("data transaction without ack in receive phase");

	a_timeout: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_TIMEOUT || status == ST_ABANDONED
			|| status == ST_COMPLETE) |-> phase_now == PH_IDLE && payload_bytes == 10'd0)
		else $error("session end did not return to idle");

endmodule

bind stop_and_wait_receiver swr_checker u_swr_checker (.*);

/* sim/swr_scoreboard_pkg.sv */
// Scoreboard for the stop-and-wait receiver bench: predicts each result from the
// accepted transactions and checks the block's results in order.
// Depends on swr_pkg.
package swr_scoreboard_pkg;
	import swr_pkg::*;

	typedef struct packed {
		logic        send;
		logic [7:0]  rtype;
		logic [31:0] rseq;
		logic [9:0]  payload;
		logic [2:0]  status;
		logic [1:0]  phase;
		logic [18:0] wait_us;
	} reply_t;

	class receiver_scoreboard;
		logic [5:0]  start_level;
		logic [5:0]  recv_give_up;
		logic [5:0]  stop_give_up;
		phase_t      phase;
		logic [31:0] next_seq;
		logic [5:0]  level;
		reply_t      expected_q[$];
		int          errors;
		int          checked;

		function new();
			start_level  = 6'd10;
			recv_give_up = 6'd40;
			stop_give_up = 6'd32;
			phase        = PH_IDLE;
			next_seq     = '0;
			level        = '0;
			errors       = 0;
			checked      = 0;
		endfunction

		function void write_register(cfg_reg_t idx, logic [5:0] value);
			case (idx)
				CFG_START_LEVEL:  start_level  = value;
				CFG_RECV_GIVE_UP: recv_give_up = value;
				CFG_STOP_GIVE_UP: stop_give_up = value;
				default: ;
			endcase
		endfunction

		function logic [18:0] backoff_us(logic [5:0] lvl);
			logic [18:0] steps [10] = '{19'd1000, 19'd2000, 19'd4000, 19'd8000, 19'd16000,
				19'd31000, 19'd63000, 19'd125000, 19'd250000, 19'd500000};
			int slot;
			slot = (lvl > 6'd39) ? 39 : int'(lvl);
			return steps[slot / 4];
		endfunction

		function void raise_level();
			if (level < TOP_LEVEL)
				level = level + 6'd1;
		endfunction

		function reply_t note_item(logic cmd, logic [7:0] typ, logic [31:0] seq, logic [9:0] len);
			reply_t      r;
			logic [9:0]  plen;
			logic [9:0]  body;
			logic        pkt_ok;
			phase_t      ph;
			r      = '0;
			plen   = (len > MAX_PACKET_BYTES) ? MAX_PACKET_BYTES : len;
			pkt_ok = !cmd && (plen >= HEADER_BYTES);
			ph     = phase;
			case (ph)
				PH_RECV: begin
					if (cmd) begin
						r.send  = 1'b1;
						r.rtype = RPL_ACK;
						r.rseq  = next_seq;
						raise_level();
						if (level >= recv_give_up) begin
							r.status = ST_TIMEOUT;
							ph       = PH_IDLE;
						end
					end else if (pkt_ok && (typ == PKT_SEND || typ == PKT_STOP) && seq == next_seq) begin
						body     = plen - HEADER_BYTES;
						next_seq = next_seq + 32'(body);
						level    = start_level;
						r.send   = 1'b1;
						r.rseq   = next_seq;
						if (typ == PKT_STOP) begin
							r.rtype  = RPL_STOP_ACK;
							r.status = ST_STOP_SEEN;
							ph       = PH_STOP;
						end else begin
							r.rtype   = RPL_ACK;
							r.payload = body;
							r.status  = ST_DATA;
						end
					end
				end
				PH_STOP: begin
					if (cmd) begin
						raise_level();
						if (level >= stop_give_up) begin
							r.status = ST_ABANDONED;
							ph       = PH_IDLE;
						end else begin
							r.send  = 1'b1;
							r.rtype = RPL_STOP_ACK;
							r.rseq  = next_seq;
						end
					end else if (pkt_ok && typ == PKT_STOP_REALLY && seq == next_seq) begin
						r.status = ST_COMPLETE;
						ph       = PH_IDLE;
					end
				end
				default: begin
					ph = PH_IDLE;
					if (pkt_ok && typ == PKT_INIT) begin
						next_seq = seq;
						r.send   = 1'b1;
						r.rtype  = RPL_INIT_ACK;
						r.rseq   = seq;
						r.status = ST_OPENED;
						ph       = PH_RECV;
						level    = start_level;
					end
				end
			endcase
			phase     = ph;
			r.phase   = ph;
			r.wait_us = (ph == PH_IDLE) ? '0 : backoff_us(level);
			expected_q.push_back(r);
			return r;
		endfunction

		function void compare_field(string fname, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				if (errors <= 50)
					$display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, want, got);
			end
		endfunction

		function void check_reply(reply_t got);
			reply_t want;
			checked++;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 50)
					$display("%0t: result with nothing expected: expected none, actual %h", $time, got);
				return;
			end
			want = expected_q.pop_front();
			compare_field("send_reply", 32'(want.send), 32'(got.send));
			compare_field("reply_type", 32'(want.rtype), 32'(got.rtype));
			compare_field("reply_seq", want.rseq, got.rseq);
			compare_field("payload_bytes", 32'(want.payload), 32'(got.payload));
			compare_field("status", 32'(want.status), 32'(got.status));
			compare_field("phase_now", 32'(want.phase), 32'(got.phase));
			compare_field("wait_us", 32'(want.wait_us), 32'(got.wait_us));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

endpackage

/* sim/tb_stop_and_wait_receiver.sv */
// Bench for the stop-and-wait receiver: directed session cases, then random
// sessions under several register settings with random idling on both sides.
// Depends on swr_pkg and swr_scoreboard_pkg.
module tb_stop_and_wait_receiver;
	import swr_pkg::*;
	import swr_scoreboard_pkg::*;

	localparam int NUM_SETTINGS = 7;
	localparam int ACTIVE_PER_SETTING = 45;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        command;
	logic [7:0]  pkt_type;
	logic [31:0] pkt_seq;
	logic [9:0]  pkt_length;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        send_reply;
	logic [7:0]  reply_type;
	logic [31:0] reply_seq;
	logic [9:0]  payload_bytes;
	logic [2:0]  status;
	logic [1:0]  phase_now;
	logic [18:0] wait_us;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [5:0]  cfg_data;

	receiver_scoreboard sb;
	int items_sent = 0;
	int active_items = 0;
	int settings_applied = 0;
	int burst_left = 0;
	int stall_left = 0;
	int stall_mode = 0;

	logic [5:0] start_set [NUM_SETTINGS] = '{6'd0, 6'd10, 6'd39, 6'd0, 6'd5, 6'd50, 6'd39};
	logic [5:0] recv_set  [NUM_SETTINGS] = '{6'd1, 6'd40, 6'd40, 6'd40, 6'd8, 6'd63, 6'd1};
	logic [5:0] stop_set  [NUM_SETTINGS] = '{6'd1, 6'd32, 6'd40, 6'd40, 6'd7, 6'd63, 6'd1};

	stop_and_wait_receiver dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(20, 80);
		end else begin
			stall_left = stall_left - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 9) < 6);
			default: out_stall <= (stall_left % 3 == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_reply({send_reply, reply_type, reply_seq, payload_bytes, status,
				phase_now, wait_us});
	end

	task automatic push_item(input logic c, input logic [7:0] t, input logic [31:0] s,
			input logic [9:0] l);
		reply_t r;
		command    <= c;
		pkt_type   <= t;
		pkt_seq    <= s;
		pkt_length <= l;
		in_valid   <= 1'b1;
		do @(posedge clk); while (in_stall);
		r = sb.note_item(c, t, s, l);
		items_sent++;
		if (r.send || r.status != ST_IGNORED)
			active_items++;
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(0, 12);
		end
	endtask

	task automatic quiesce();
		if (in_valid)
			in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [5:0] value);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.write_register(idx, value);
		@(negedge clk);
	endtask

	task automatic apply_setting(input int n);
		quiesce();
		write_reg(CFG_START_LEVEL, start_set[n]);
		write_reg(CFG_RECV_GIVE_UP, recv_set[n]);
		write_reg(CFG_STOP_GIVE_UP, stop_set[n]);
		cfg_valid <= 1'b0;
		settings_applied++;
	endtask

	function automatic logic [9:0] pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 10'($urandom_range(0, 11));
		if (r < 16)
			return HEADER_BYTES;
		if (r < 22)
			return 10'($urandom_range(549, 1023));
		if (r < 30)
			return MAX_PACKET_BYTES;
		return 10'($urandom_range(13, 547));
	endfunction

	function automatic logic [7:0] pick_type();
		case ($urandom_range(0, 5))
			0: return PKT_SEND;
			1: return PKT_INIT;
			2: return PKT_STOP;
			3: return PKT_STOP_REALLY;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic random_item();
		int          r;
		logic [31:0] s;
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < 25) begin
			s = $urandom_range(0, 1) ? $urandom : sb.next_seq;
			push_item(1'($urandom_range(0, 1)), pick_type(), s, pick_length());
		end else begin
			case (sb.phase)
				PH_RECV: begin
					if (r < 12)
						push_item(1'b1, 8'($urandom), $urandom, 10'($urandom));
					else if (r < 22)
						push_item(1'b0, PKT_STOP, sb.next_seq, pick_length());
					else
						push_item(1'b0, PKT_SEND, sb.next_seq, pick_length());
				end
				PH_STOP: begin
					if (r < 45)
						push_item(1'b0, PKT_STOP_REALLY, sb.next_seq, pick_length());
					else
						push_item(1'b1, 8'($urandom), $urandom, 10'($urandom));
				end
				default: begin
					if (r < 50)
						s = $urandom;
					else if (r < 75)
						s = 32'hFFFF_FFFF - $urandom_range(0, 600);
					else
						s = $urandom_range(0, 1000);
					push_item(1'b0, PKT_INIT, s, pick_length());
				end
			endcase
		end
	endtask

	task automatic directed_session();
		push_item(1'b1, 8'hFF, 32'hFFFF_FFFF, 10'h3FF);
		push_item(1'b0, PKT_SEND, 32'd0, 10'd40);
		push_item(1'b0, PKT_INIT, 32'd5, 10'd11);
		push_item(1'b0, PKT_INIT, 32'hFFFF_FFF0, 10'h3FF);
		push_item(1'b0, PKT_SEND, sb.next_seq + 32'd1, 10'd100);
		push_item(1'b0, PKT_SEND, sb.next_seq, MAX_PACKET_BYTES);
		push_item(1'b0, PKT_SEND, sb.next_seq, HEADER_BYTES);
		push_item(1'b0, PKT_SEND, sb.next_seq, 10'd549);
		push_item(1'b0, PKT_STOP_REALLY, sb.next_seq, HEADER_BYTES);
		push_item(1'b0, PKT_INIT, sb.next_seq, HEADER_BYTES);
		push_item(1'b0, 8'hFF, sb.next_seq, HEADER_BYTES);
		push_item(1'b1, 8'h00, 32'd0, 10'd0);
		push_item(1'b1, 8'hFF, 32'hFFFF_FFFF, 10'h3FF);
		push_item(1'b0, PKT_SEND, sb.next_seq, 10'd11);
		push_item(1'b0, PKT_STOP, sb.next_seq, 10'd20);
		push_item(1'b1, 8'h00, 32'd0, 10'd0);
		push_item(1'b0, PKT_SEND, sb.next_seq, HEADER_BYTES);
		push_item(1'b0, PKT_STOP_REALLY, sb.next_seq - 32'd1, HEADER_BYTES);
		push_item(1'b0, PKT_STOP_REALLY, sb.next_seq, HEADER_BYTES);
	endtask

	task automatic directed_give_up();
		push_item(1'b0, PKT_INIT, 32'd0, HEADER_BYTES);
		push_item(1'b1, 8'h00, 32'd0, 10'd0);
		push_item(1'b0, PKT_INIT, 32'hFFFF_FFFF, 10'd30);
		push_item(1'b0, PKT_STOP, sb.next_seq, HEADER_BYTES);
		push_item(1'b1, 8'h00, 32'd0, 10'd0);
	endtask

	initial begin
		int target;
		sb         = new();
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		command    = 1'b0;
		pkt_type   = '0;
		pkt_seq    = '0;
		pkt_length = '0;
		cfg_valid  = 1'b0;
		cfg_index  = CFG_START_LEVEL;
		cfg_data   = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed_session();
		apply_setting(0);
		directed_give_up();

		for (int n = 0; n < NUM_SETTINGS; n++) begin
			apply_setting(n);
			target = active_items + ACTIVE_PER_SETTING;
			while (active_items < target)
				random_item();
		end

		quiesce();
		$display("Covered %0d transactions (%0d changed state or replied), %0d results checked.",
			items_sent, active_items, sb.checked);
		$display("Register settings applied: %0d, errors: %0d, results still expected: %0d.",
			settings_applied, sb.errors, sb.pending());
		if (sb.errors == 0 && sb.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2000000;
		$display("%0t: timeout with %0d results still expected", $time, sb.pending());
		$display("DONE: errors detected");
		$finish;
	end

endmodule

/* filelist.f */
src/swr_pkg.sv
src/stop_and_wait_receiver.sv
src/swr_checker.sv
sim/swr_scoreboard_pkg.sv
sim/tb_stop_and_wait_receiver.sv
